FILE: hw/rtl/zrle_pkg.sv
// Shared types, constants and the code decode helper for the zero-run decoder.
`default_nettype none

package zrle_pkg;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_RUN = 2'd1,
    KIND_PAD = 2'd2,
    KIND_ERR = 2'd3
  } zrle_kind_e;

  typedef struct packed {
    zrle_kind_e  kind;
    logic [7:0]  data;
    logic [15:0] rep_cnt;
    logic        last;
  } zrle_res_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } zrle_push_t;

  typedef struct packed {
    logic        ok;
    logic        run;
    logic [3:0]  len;
    logic [15:0] next_bw;
  } zrle_act_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  localparam logic [3:0] RUN_BIAS   = 4'd7;
  localparam logic [4:0] LIT_BASE   = 5'd8;

  // Decode one 4-bit code against the output budget.
  function automatic zrle_act_t act_code(logic [3:0] code, logic [15:0] base,
                                         logic [15:0] limit);
    zrle_act_t   a;
    logic [16:0] sum;
    a.run     = code[3];
    a.len     = code[3] ? 4'(code - RUN_BIAS) : 4'(LIT_BASE - {1'b0, code});
    sum       = {1'b0, base} + {13'd0, a.len};
    a.ok      = (sum <= {1'b0, limit});
    a.next_bw = sum[15:0];
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/zrle_core.sv
// Per-byte decode: packet state, output budget and up to two results per item.
`default_nettype none

module zrle_core import zrle_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              fire_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output zrle_push_t             push_o,
  output zrle_res_t [1:0]        res_o
);

  logic        phase_q, phase_d;
  logic [3:0]  held_q, held_d;
  logic [3:0]  left_q, left_d;
  logic [15:0] bw_q, bw_d;
  logic        drop_q, drop_d;
  logic [15:0] limit_q;

  logic        lit_path;
  logic [3:0]  code2;
  logic [15:0] base2;
  zrle_act_t   act1, act2;
  logic        do_hi;
  logic        ok;
  logic [1:0]  nres;
  logic [15:0] pad;

  assign lit_path = (left_q != 4'd0);
  assign act1     = act_code(byte_i[3:0], bw_q, limit_q);
  assign code2    = lit_path ? held_q : byte_i[7:4];
  assign base2    = lit_path ? (bw_q + 16'd1) : act1.next_bw;
  assign act2     = act_code(code2, base2, limit_q);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    left_d  = left_q;
    bw_d    = bw_q;
    drop_d  = drop_q;
    res_o   = '0;
    nres    = 2'd0;
    ok      = 1'b1;
    do_hi   = 1'b0;
    pad     = 16'd0;
    if (drop_q) begin
      if (last_i) begin
        drop_d  = 1'b0;
        phase_d = 1'b0;
        held_d  = 4'd0;
        left_d  = 4'd0;
        bw_d    = 16'd0;
      end
    end else begin
      if (lit_path) begin
        res_o[nres[0]] = '{kind: KIND_LIT, data: byte_i, rep_cnt: 16'd1, last: 1'b0};
        nres   = nres + 2'd1;
        bw_d   = bw_q + 16'd1;
        left_d = left_q - 4'd1;
        do_hi  = (left_q == 4'd1) && phase_q && !last_i;
      end else begin
        held_d  = byte_i[7:4];
        phase_d = 1'b1;
        if (!act1.ok) begin
          ok = 1'b0;
        end else if (act1.run) begin
          res_o[nres[0]] = '{kind: KIND_RUN, data: 8'd0, rep_cnt: {12'd0, act1.len},
                             last: 1'b0};
          nres  = nres + 2'd1;
          bw_d  = act1.next_bw;
          do_hi = !last_i;
        end else begin
          left_d = act1.len;
        end
      end
      // high nibble of the control byte, held or current
      if (do_hi) begin
        phase_d = 1'b0;
        if (!act2.ok) begin
          ok = 1'b0;
        end else if (act2.run) begin
          res_o[nres[0]] = '{kind: KIND_RUN, data: 8'd0, rep_cnt: {12'd0, act2.len},
                             last: 1'b0};
          nres = nres + 2'd1;
          bw_d = act2.next_bw;
        end else begin
          left_d = act2.len;
        end
      end
      pad = (limit_q > bw_d) ? (limit_q - bw_d) : 16'd0;
      if (!ok || last_i) begin
        if (!ok) begin
          res_o[nres[0]] = '{kind: KIND_ERR, data: 8'd0, rep_cnt: 16'd0, last: last_i};
          drop_d = !last_i;
        end else begin
          res_o[nres[0]] = '{kind: KIND_PAD, data: 8'd0, rep_cnt: pad, last: 1'b1};
        end
        nres    = nres + 2'd1;
        phase_d = 1'b0;
        held_d  = 4'd0;
        left_d  = 4'd0;
        bw_d    = 16'd0;
      end
    end
  end

  assign push_o.v0 = fire_i && (nres != 2'd0);
  assign push_o.v1 = fire_i && (nres == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      held_q  <= 4'd0;
      left_q  <= 4'd0;
      bw_q    <= 16'd0;
      drop_q  <= 1'b0;
      limit_q <= 16'hffff;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        left_q  <= left_d;
        bw_q    <= bw_d;
        drop_q  <= drop_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (left_q == 4'd0) && (bw_q == 16'd0))
    else $error("packet state not cleared while dropping");

  a_end_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i && !drop_q |->
      push_o.v0 && (push_o.v1 ? res_o[1].last : res_o[0].last))
    else $error("packet end without marked final result");

  a_no_early_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !last_i |-> !res_o[0].last && !res_o[1].last)
    else $error("block end marked before last byte");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> (bw_q == 16'd0) && (left_q == 4'd0) && !phase_q && !drop_q)
    else $error("packet state survives last byte");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/zrle_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module zrle_fifo import zrle_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire zrle_push_t        push_i,
  input  wire zrle_res_t [1:0]   res_i,
  input  wire logic              pop_i,
  output zrle_res_t              head_o,
  output logic                   valid_o,
  output logic                   room_o
);

  zrle_res_t  mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       npush;

  assign npush   = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign wp_d    = wp_q + PTR_W'(npush);
  assign rp_d    = rp_q + PTR_W'(pop_i);
  assign count_d = count_q + CNT_W'(npush) - CNT_W'(pop_i);

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rp_q];
  // room for a full pair of results, whatever the reader does this cycle
  assign room_o  = (count_q <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wp_q] <= res_i[0];
    end
    if (push_i.v1) begin
      mem_q[wp_q + PTR_W'(1)] <= res_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> room_o)
    else $error("results pushed without room");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/zero_rle_decoder.sv
// Zero-run decoder top level: input register, decode core and result queue.
//
// Input stream (s_axis): one compressed byte per item, tlast on the packet's
// final byte. Output stream (m_axis): one decoded result per item, tuser the
// kind (literal, zero run, end padding, overflow error), tdata the literal
// byte and repeat count, tlast on the final result of a packet (not when an
// error ended it early). cfg_we_i/cfg_wdata_i load the output limit in
// bytes; write it only while the block is idle.
// Path: an accepted byte waits in the input register until the queue has
// room; then it is decoded and its results go into the result queue.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver takes every result; a byte that gives two results (a literal
// or run then a run, padding or an error) is absorbed by a four-deep result
// queue. Input is taken while the input register is empty or the queue
// holds two results or fewer. When the receiver stalls, the queue fills and
// s_axis_tready falls; no result is lost. Reset empties the queue and input
// register, clears the packet state and sets the limit to 65535.
`default_nettype none

module zero_rle_decoder import zrle_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] repeat_count
  output logic [1:0]       m_axis_tuser,   // [1:0] item_kind
  output logic             m_axis_tlast    // block_end
);

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       room;
  logic       fire;
  logic       take;

  zrle_push_t       push;
  zrle_res_t [1:0]  res;
  zrle_res_t        head;

  assign fire          = in_v_q && room;
  assign s_axis_tready = !in_v_q || room;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign in_v_d        = take ? 1'b1 : (fire ? 1'b0 : in_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  zrle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .push_o      (push),
    .res_o       (res)
  );

  zrle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .pop_i   (m_axis_tvalid && m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  assign m_axis_tdata = {head.rep_cnt, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
